FILE: sv/rhr_pkg.sv
// Shared types, widths and a helper function for the RGB hue rotator.
package rhr_pkg;

	localparam int CH_W   = 8;
	localparam int AMT_W  = 16;
	localparam int SPAN_W = 11;
	localparam int SUM_W  = 17;
	localparam int Q_W    = 14;
	localparam int PROD_W = AMT_W + SPAN_W;
	localparam int S3_LO  = 10;
	localparam int S4_LO  = 5;
	localparam int LAT    = 6;
	localparam int IN_W   = 4 * CH_W + AMT_W;
	localparam int OUT_W  = 4 * CH_W;

	typedef enum logic [1:0] {
		CH_R,
		CH_G,
		CH_B
	} chan_t;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgba_t;

	typedef struct packed {
		rgba_t             pix;
		logic              grey;
		logic [CH_W-1:0]   hi;
		logic [CH_W-1:0]   lo;
		logic [CH_W-1:0]   d;
		logic [SPAN_W-1:0] span;
	} ctx_t;

	typedef struct packed {
		logic [SPAN_W-1:0] m2;
		logic [SPAN_W-1:0] m3;
		logic [SPAN_W-1:0] m4;
		logic [SPAN_W-1:0] m5;
	} mult_t;

	// one restoring step of rem mod span, at weight 2**k
	function automatic logic [SUM_W-1:0] mod_step(input logic [SUM_W-1:0] rem,
			input logic [SPAN_W-1:0] span, input int k);
		logic [SUM_W+Q_W-1:0] sh;
		logic [SUM_W+Q_W-1:0] r;
		sh = {{(SUM_W + Q_W - SPAN_W){1'b0}}, span} << k;
		r  = {{Q_W{1'b0}}, rem};
		if (r >= sh) begin
			r = r - sh;
		end
		return r[SUM_W-1:0];
	endfunction

endpackage

FILE: sv/rgb_hue_rotator.sv
// Hue rotator: six-stage pipeline turning one RGBA8 pixel per cycle around its hexcone
// while m_tready does not stall it; each accepted request passes registers s1 to s6.
// Throughput: one pixel per cycle while unstalled; the (pos + steps) mod span remainder
// is a restoring divider spread one bit per step over stages three to five.
// Reset: arst_n clears every valid bit at once; s_tready stays low in reset and until
// rst_done_q is registered high after it. Payload registers are not reset.
module rgb_hue_rotator
	import rhr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // red, green, blue, alpha, amount
	input  logic             s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // out_red, out_green, out_blue, out_alpha
);

	logic rst_done_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	ctx_t              ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	mult_t             mult_s2, mult_s3, mult_s4, mult_s5;
	logic              kind_s1;
	logic [AMT_W-1:0]  amt_s1;
	logic [SPAN_W-1:0] pos_s1, pos_s2;
	logic [AMT_W-1:0]  steps_s2;
	logic [SUM_W-1:0]  rem_s3, rem_s4, rem_s5;
	rgba_t             out_s6;

	// stage 1 inputs
	logic [CH_W-1:0]   r, g, b, hi, lo, d;
	logic [CH_W-1:0]   rl, gl, bl;
	logic [SPAN_W-1:0] de, span, pos;
	chan_t             hid, lid;
	rgba_t             pix;

	// later stages
	logic [PROD_W-1:0] prod;
	logic [AMT_W-1:0]  steps;
	mult_t             mult;
	logic [SUM_W-1:0]  rem3, rem4, rem5;
	logic [SPAN_W-1:0] p, base;
	logic [CH_W-1:0]   f;
	rgba_t             res;

	assign en_s6    = !v_s6 || m_tready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1 && rst_done_q;
	assign m_tvalid = v_s6;
	assign m_tdata  = out_s6;

	// stage 1: extremes, span and position
	always_comb begin
		r   = s_tdata[CH_W-1:0];
		g   = s_tdata[2*CH_W-1:CH_W];
		b   = s_tdata[3*CH_W-1:2*CH_W];
		pix = '{alpha: s_tdata[4*CH_W-1:3*CH_W], blue: b, green: g, red: r};

		priority if (r >= g && r > b) begin
			hi = r; hid = CH_R;
		end else if (g >= b && g > r) begin
			hi = g; hid = CH_G;
		end else if (b >= r && b > g) begin
			hi = b; hid = CH_B;
		end else begin
			hi = r; hid = CH_R;
		end

		priority if (b <= r && b < g) begin
			lo = b; lid = CH_B;
		end else if (r <= g && r < b) begin
			lo = r; lid = CH_R;
		end else if (g <= b && g < r) begin
			lo = g; lid = CH_G;
		end else begin
			lo = r; lid = CH_R;
		end

		d    = hi - lo;
		de   = SPAN_W'(d);
		span = (de << 2) + (de << 1);
		rl   = r - lo;
		gl   = g - lo;
		bl   = b - lo;

		priority if (hid == CH_R && lid == CH_B) begin
			pos = SPAN_W'(gl);
		end else if (hid == CH_G && lid == CH_B) begin
			pos = (de << 1) - SPAN_W'(rl);
		end else if (hid == CH_G && lid == CH_R) begin
			pos = SPAN_W'(bl) + (de << 1);
		end else if (hid == CH_B && lid == CH_R) begin
			pos = (de << 2) - SPAN_W'(gl);
		end else if (hid == CH_B && lid == CH_G) begin
			pos = SPAN_W'(rl) + (de << 2);
		end else begin
			pos = span - SPAN_W'(bl);
		end
	end

	// stage 2: fraction scaling and span multiples
	always_comb begin
		prod    = PROD_W'(amt_s1) * PROD_W'(ctx_s1.span);
		steps   = kind_s1 ? AMT_W'(prod[PROD_W-1:AMT_W]) : amt_s1;
		mult.m2 = SPAN_W'(ctx_s1.d) << 1;
		mult.m4 = SPAN_W'(ctx_s1.d) << 2;
		mult.m3 = mult.m2 + SPAN_W'(ctx_s1.d);
		mult.m5 = mult.m4 + SPAN_W'(ctx_s1.d);
	end

	// stages 3 to 5: (pos + steps) mod span
	always_comb begin
		rem3 = SUM_W'(pos_s2) + SUM_W'(steps_s2);
		for (int k = Q_W - 1; k >= S3_LO; k--) begin
			rem3 = mod_step(rem3, ctx_s2.span, k);
		end
		rem4 = rem_s3;
		for (int k = S3_LO - 1; k >= S4_LO; k--) begin
			rem4 = mod_step(rem4, ctx_s3.span, k);
		end
		rem5 = rem_s4;
		for (int k = S4_LO - 1; k >= 0; k--) begin
			rem5 = mod_step(rem5, ctx_s4.span, k);
		end
	end

	// stage 6: zone and offset back to RGB
	always_comb begin
		p         = rem_s5[SPAN_W-1:0];
		res.alpha = ctx_s5.pix.alpha;
		priority if (p >= mult_s5.m5) begin
			base = mult_s5.m5;
		end else if (p >= mult_s5.m4) begin
			base = mult_s5.m4;
		end else if (p >= mult_s5.m3) begin
			base = mult_s5.m3;
		end else if (p >= mult_s5.m2) begin
			base = mult_s5.m2;
		end else if (p >= SPAN_W'(ctx_s5.d)) begin
			base = SPAN_W'(ctx_s5.d);
		end else begin
			base = '0;
		end
		f = CH_W'(p - base);

		priority if (ctx_s5.grey) begin
			res.red = ctx_s5.pix.red; res.green = ctx_s5.pix.green; res.blue = ctx_s5.pix.blue;
		end else if (p >= mult_s5.m5) begin
			res.red = ctx_s5.hi; res.green = ctx_s5.lo; res.blue = ctx_s5.hi - f;
		end else if (p >= mult_s5.m4) begin
			res.red = ctx_s5.lo + f; res.green = ctx_s5.lo; res.blue = ctx_s5.hi;
		end else if (p >= mult_s5.m3) begin
			res.red = ctx_s5.lo; res.green = ctx_s5.hi - f; res.blue = ctx_s5.hi;
		end else if (p >= mult_s5.m2) begin
			res.red = ctx_s5.lo; res.green = ctx_s5.hi; res.blue = ctx_s5.lo + f;
		end else if (p >= SPAN_W'(ctx_s5.d)) begin
			res.red = ctx_s5.hi - f; res.green = ctx_s5.hi; res.blue = ctx_s5.lo;
		end else begin
			res.red = ctx_s5.hi; res.green = ctx_s5.lo + f; res.blue = ctx_s5.lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_done_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			rst_done_q <= 1'b1;
			if (en_s1) v_s1 <= s_tvalid && s_tready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ctx_s1  <= '{pix: pix, grey: (hi <= lo), hi: hi, lo: lo, d: d, span: span};
			kind_s1 <= s_tuser;
			amt_s1  <= s_tdata[IN_W-1:4*CH_W];
			pos_s1  <= pos;
		end
		if (en_s2 && v_s1) begin
			ctx_s2   <= ctx_s1;
			mult_s2  <= mult;
			pos_s2   <= pos_s1;
			steps_s2 <= steps;
		end
		if (en_s3 && v_s2) begin
			ctx_s3  <= ctx_s2;
			mult_s3 <= mult_s2;
			rem_s3  <= rem3;
		end
		if (en_s4 && v_s3) begin
			ctx_s4  <= ctx_s3;
			mult_s4 <= mult_s3;
			rem_s4  <= rem4;
		end
		if (en_s5 && v_s4) begin
			ctx_s5  <= ctx_s4;
			mult_s5 <= mult_s4;
			rem_s5  <= rem5;
		end
		if (en_s6 && v_s5) begin
			out_s6 <= res;
		end
	end

endmodule

FILE: sv/rhr_checker.sv
// Port-level checks for the hue rotator, bound to its top level.
module rhr_checker
	import rhr_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,   // red, green, blue, alpha, amount
	input logic             s_tuser,   // kind
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata    // out_red, out_green, out_blue, out_alpha
);

	localparam int RUN_W = $clog2(LAT);

	logic [RUN_W-1:0] run_q;
	logic             acc, grey_in, flow;

	assign acc     = s_tvalid && s_tready;
	assign grey_in = (s_tdata[CH_W-1:0] == s_tdata[2*CH_W-1:CH_W]) &&
			(s_tdata[2*CH_W-1:CH_W] == s_tdata[3*CH_W-1:2*CH_W]);
	assign flow    = (run_q == RUN_W'(LAT - 1));

	// consecutive cycles of m_tready, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (!m_tready) begin
			run_q <= '0;
		end else if (!flow) begin
			run_q <= run_q + 1'b1;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_alpha_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc, LAT) && $past(arst_n, LAT) && flow |->
		m_tvalid && m_tdata[4*CH_W-1:3*CH_W] == $past(s_tdata[4*CH_W-1:3*CH_W], LAT))
		else $error("alpha lost or latency wrong");

	a_grey_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc && grey_in, LAT) && $past(arst_n, LAT) && flow |->
		m_tdata[3*CH_W-1:0] == $past(s_tdata[3*CH_W-1:0], LAT))
		else $error("grey pixel altered");

endmodule

bind rgb_hue_rotator rhr_checker u_rhr_checker (.*);
